// ===== design/brn_pkg.sv =====
`timescale 1ns / 1ps

package brn_pkg;

  localparam int unsigned ValueWidth = 12;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned NumDigits  = 4;
  localparam int unsigned MaxValue   = 3999;

  localparam int unsigned DEC_WEIGHT [3] = '{1000, 100, 10};

  localparam logic [CharWidth-1:0] CHAR_NONE = 8'h00;
  localparam logic [CharWidth-1:0] CHAR_I    = 8'h49;
  localparam logic [CharWidth-1:0] CHAR_V    = 8'h56;
  localparam logic [CharWidth-1:0] CHAR_X    = 8'h58;
  localparam logic [CharWidth-1:0] CHAR_L    = 8'h4C;
  localparam logic [CharWidth-1:0] CHAR_C    = 8'h43;
  localparam logic [CharWidth-1:0] CHAR_D    = 8'h44;
  localparam logic [CharWidth-1:0] CHAR_M    = 8'h4D;

  localparam logic [1:0] POS_ONES  = 2'd0;
  localparam logic [1:0] POS_TENS  = 2'd1;
  localparam logic [1:0] POS_HUNDS = 2'd2;
  localparam logic [1:0] POS_THOUS = 2'd3;

  typedef logic [NumDigits-1:0][3:0] digits_t;

  typedef enum logic [1:0] {
    KIND_NUMERAL,
    KIND_ZERO,
    KIND_RANGE
  } kind_e;

  typedef struct packed {
    kind_e   kind;
    digits_t digits;
  } entry_t;

  // split a value below 4000 into decimal digits, index 3 is thousands
  function automatic digits_t dec_split(logic [ValueWidth-1:0] v);
    logic [ValueWidth-1:0] r;
    digits_t dg;
    r  = v;
    dg = '0;
    for (int k = 0; k < 3; k++) begin
      for (int d = 1; d < 10; d++) begin
        if (int'(r) >= d * int'(DEC_WEIGHT[k])) begin
          dg[3-k] = 4'(d);
        end
      end
      r = r - ValueWidth'(int'(dg[3-k]) * int'(DEC_WEIGHT[k]));
    end
    dg[0] = r[3:0];
    return dg;
  endfunction

  // number of symbols one digit takes
  function automatic logic [2:0] len_of(logic [3:0] d);
    logic [2:0] n;
    case (d) inside
      4'd1, 4'd2, 4'd3:         n = d[2:0];
      4'd4, 4'd9:               n = 3'd2;
      4'd5, 4'd6, 4'd7, 4'd8:   n = 3'(d - 4'd4);
      default:                  n = 3'd0;
    endcase
    return n;
  endfunction

  // symbol number step of digit d at decimal position pos
  function automatic logic [CharWidth-1:0] sym_of(logic [1:0] pos, logic [3:0] d,
                                                  logic [1:0] step);
    logic [CharWidth-1:0] one;
    logic [CharWidth-1:0] five;
    logic [CharWidth-1:0] ten;
    logic [CharWidth-1:0] s;
    case (pos)
      POS_ONES:  begin one = CHAR_I; five = CHAR_V; ten = CHAR_X; end
      POS_TENS:  begin one = CHAR_X; five = CHAR_L; ten = CHAR_C; end
      POS_HUNDS: begin one = CHAR_C; five = CHAR_D; ten = CHAR_M; end
      default:   begin one = CHAR_M; five = CHAR_M; ten = CHAR_M; end
    endcase
    case (d) inside
      4'd9:                   s = (step == 2'd0) ? one : ten;
      4'd4:                   s = (step == 2'd0) ? one : five;
      4'd5, 4'd6, 4'd7, 4'd8: s = (step == 2'd0) ? five : one;
      default:                s = one;
    endcase
    return s;
  endfunction

  // highest nonzero digit below position lim, bit 2 set when found
  function automatic logic [2:0] next_pos(digits_t dg, logic [2:0] lim);
    logic [2:0] res;
    res = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (3'(i) < lim && dg[i] != 4'd0) begin
        res = {1'b1, 2'(i)};
      end
    end
    return res;
  endfunction

endpackage

// ===== design/brn_front.sv =====
`timescale 1ns / 1ps

module brn_front (
  input  logic [brn_pkg::ValueWidth-1:0] value_i,
  output brn_pkg::entry_t                entry_o
);
  import brn_pkg::*;

  always_comb begin
    entry_o.digits = dec_split(value_i);
    if (value_i == '0) begin
      entry_o.kind = KIND_ZERO;
    end else if (int'(value_i) > int'(MaxValue)) begin
      entry_o.kind = KIND_RANGE;
    end else begin
      entry_o.kind = KIND_NUMERAL;
    end
  end

endmodule

// ===== design/brn_queue.sv =====
`timescale 1ns / 1ps

module brn_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  brn_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output brn_pkg::entry_t data_o
);
  import brn_pkg::*;

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/brn_back.sv =====
`timescale 1ns / 1ps

module brn_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  brn_pkg::entry_t               q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [brn_pkg::CharWidth-1:0] character_o,
  output logic                          empty_res_o,
  output logic                          out_of_range_o,
  output logic                          last_o
);
  import brn_pkg::*;

  entry_t               entry_q;
  logic                 busy_q, busy_d;
  logic [1:0]           pos_q, pos_d;
  logic [1:0]           step_q, step_d;
  logic                 out_valid_q;
  logic [CharWidth-1:0] char_q;
  logic                 empty_q;
  logic                 oor_q;
  logic                 last_q;

  logic                 out_load;
  logic                 emit;
  logic                 special;
  logic [2:0]           cur_len;
  logic                 last_in_digit;
  logic [2:0]           nxt;
  logic [2:0]           first;
  logic                 emit_last;
  logic [CharWidth-1:0] sym;

  always_comb begin
    out_load      = !out_valid_q || !out_stall_i;
    emit          = busy_q && out_load;
    special       = (entry_q.kind != KIND_NUMERAL);
    cur_len       = len_of(entry_q.digits[pos_q]);
    last_in_digit = ({1'b0, step_q} + 3'd1) == cur_len;
    nxt           = next_pos(entry_q.digits, {1'b0, pos_q});
    first         = next_pos(q_data_i.digits, 3'd4);
    emit_last     = special || (last_in_digit && !nxt[2]);
    sym           = sym_of(pos_q, entry_q.digits[pos_q], step_q);
    q_pop_o       = q_valid_i && (!busy_q || (emit && emit_last));

    busy_d = busy_q;
    pos_d  = pos_q;
    step_d = step_q;
    if (q_pop_o) begin
      busy_d = 1'b1;
      pos_d  = first[1:0];
      step_d = 2'd0;
    end else if (emit && emit_last) begin
      busy_d = 1'b0;
    end else if (emit) begin
      if (last_in_digit) begin
        pos_d  = nxt[1:0];
        step_d = 2'd0;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      step_q <= step_d;
      if (out_load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      entry_q <= q_data_i;
    end
    if (emit) begin
      char_q  <= special ? CHAR_NONE : sym;
      empty_q <= special;
      oor_q   <= (entry_q.kind == KIND_RANGE);
      last_q  <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign character_o    = char_q;
  assign empty_res_o    = empty_q;
  assign out_of_range_o = oor_q;
  assign last_o         = last_q;

endmodule

// ===== design/binary_to_roman_numeral.sv =====
`timescale 1ns / 1ps
// binary to roman numeral converter
// input channel: in_valid_i / in_stall_o with value_i, one 12-bit word per item
// output channel: out_valid_o / out_stall_i, one word per roman symbol:
//   character_o (ascii I V X L C D M), empty_res_o, out_of_range_o, last_o
// last_o marks the final word of each item
// value 0 gives one empty word; 4000 and above give one empty word with
//   out_of_range_o set
// an accepted item passes the queue, the back end's entry register and the output
//   word register before its first word appears
// throughput: one output word per cycle while out_stall_i is low; an item takes
//   one word per symbol of its numeral (1 to 15 words, empty results count as 1);
//   the symbol sequencer in the back end emits one word per cycle and sets this figure
// a queue of QUEUE_DEPTH items decouples decode from emission; in_stall_o
//   rises only when that queue is full
// while out_stall_i is high a shown output word holds and the sequencer waits
// reset clears the queue and the sequencer; no word is shown until new input
module binary_to_roman_numeral #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [brn_pkg::ValueWidth-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [brn_pkg::CharWidth-1:0] character_o,
  output logic                          empty_res_o,
  output logic                          out_of_range_o,
  output logic                          last_o
);
  import brn_pkg::*;

  entry_t front_entry;
  entry_t q_data;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  logic   q_push;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  brn_front u_front (
    .value_i (value_i),
    .entry_o (front_entry)
  );

  brn_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  brn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .character_o    (character_o),
    .empty_res_o    (empty_res_o),
    .out_of_range_o (out_of_range_o),
    .last_o         (last_o)
  );

endmodule

// ===== design/brn_checker.sv =====
`timescale 1ns / 1ps

module brn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [brn_pkg::ValueWidth-1:0] value_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [brn_pkg::CharWidth-1:0] character_o,
  input logic                          empty_res_o,
  input logic                          out_of_range_o,
  input logic                          last_o
);
  import brn_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(value_i))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o) && $stable(last_o))
    else $error("output word changed while stalled");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_o && character_o == CHAR_NONE)
    else $error("empty word not final or carries a character");

  a_range_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> empty_res_o)
    else $error("out of range word carries a character");

  a_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !empty_res_o |->
      character_o == CHAR_I || character_o == CHAR_V || character_o == CHAR_X ||
      character_o == CHAR_L || character_o == CHAR_C || character_o == CHAR_D ||
      character_o == CHAR_M)
    else $error("character is not a roman symbol");

endmodule

bind binary_to_roman_numeral brn_checker u_brn_checker (.*);

// ===== verif/roman_checker.sv =====
`timescale 1ns / 1ps

module roman_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [brn_pkg::ValueWidth-1:0] value_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [brn_pkg::CharWidth-1:0]  character_i,
  input  logic                           empty_res_i,
  input  logic                           out_of_range_i,
  input  logic                           last_i,
  output int                             errors_o,
  output int                             pending_o
);

  import brn_pkg::*;

  typedef struct {
    logic [CharWidth-1:0] character;
    logic                 empty_res;
    logic                 out_of_range;
    logic                 last;
  } roman_word_t;

  roman_word_t roman_q [$];

  // expected symbol words of one value
  task automatic spell_value(input logic [ValueWidth-1:0] v);
    logic [CharWidth-1:0] syms [$];
    logic [CharWidth-1:0] one;
    logic [CharWidth-1:0] five;
    logic [CharWidth-1:0] ten;
    roman_word_t          w;
    int unsigned          n;
    int unsigned          scale;
    int unsigned          d;
    n = 32'(v);
    if (n == 0 || n > MaxValue) begin
      w.character    = CHAR_NONE;
      w.empty_res    = 1'b1;
      w.out_of_range = (n > MaxValue);
      w.last         = 1'b1;
      roman_q.push_back(w);
      return;
    end
    scale = 1000;
    for (int p = 3; p >= 0; p--) begin
      d = (n / scale) % 10;
      case (p)
        3: begin one = CHAR_M; five = CHAR_M; ten = CHAR_M; end
        2: begin one = CHAR_C; five = CHAR_D; ten = CHAR_M; end
        1: begin one = CHAR_X; five = CHAR_L; ten = CHAR_C; end
        default: begin one = CHAR_I; five = CHAR_V; ten = CHAR_X; end
      endcase
      if (d == 9) begin
        syms.push_back(one);
        syms.push_back(ten);
      end else if (d == 4) begin
        syms.push_back(one);
        syms.push_back(five);
      end else begin
        if (d >= 5) begin
          syms.push_back(five);
          d = d - 5;
        end
        repeat (d) syms.push_back(one);
      end
      scale = scale / 10;
    end
    foreach (syms[i]) begin
      w.character    = syms[i];
      w.empty_res    = 1'b0;
      w.out_of_range = 1'b0;
      w.last         = (i == syms.size() - 1);
      roman_q.push_back(w);
    end
  endtask

  always @(posedge clk_i) begin : watch
    roman_word_t exp_w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        spell_value(value_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (roman_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected word char=%h empty=%b range=%b last=%b", $realtime,
                   character_i, empty_res_i, out_of_range_i, last_i);
        end else begin
          exp_w = roman_q.pop_front();
          if (character_i !== exp_w.character || empty_res_i !== exp_w.empty_res ||
              out_of_range_i !== exp_w.out_of_range || last_i !== exp_w.last) begin
            errors_o++;
            $display("%0t: mismatch expected char=%h empty=%b range=%b last=%b", $realtime,
                     exp_w.character, exp_w.empty_res, exp_w.out_of_range, exp_w.last);
            $display("%0t:          actual   char=%h empty=%b range=%b last=%b", $realtime,
                     character_i, empty_res_i, out_of_range_i, last_i);
          end
        end
      end
    end
    pending_o <= roman_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 300;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [brn_pkg::ValueWidth-1:0] value_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [brn_pkg::CharWidth-1:0]  character_o;
  logic                           empty_res_o;
  logic                           out_of_range_o;
  logic                           last_o;

  int errors;
  int pending;
  int cycle_count = 0;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit draining = 1'b0;

  int unsigned corner_vals [25] = '{
    0, 1, 3999, 4000, 4095, 3888, 4, 9, 40, 90, 400, 900, 5, 8,
    50, 80, 500, 800, 1000, 2000, 3000, 14, 1994, 2048, 3
  };

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  binary_to_roman_numeral uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .character_o   (character_o),
    .empty_res_o   (empty_res_o),
    .out_of_range_o(out_of_range_o),
    .last_o        (last_o)
  );

  roman_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .character_i   (character_o),
    .empty_res_i   (empty_res_o),
    .out_of_range_i(out_of_range_o),
    .last_i        (last_o),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic offer_value(input logic [brn_pkg::ValueWidth-1:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // wait until every expected word has come out
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // output side stalls
  initial begin : rx
    int n;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HoldCycles;
      end else if (calm || draining) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 17);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : tx
    int                           sel;
    logic [brn_pkg::ValueWidth-1:0] v;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_vals[i]) begin
      offer_value(brn_pkg::ValueWidth'(corner_vals[i]));
    end
    in_valid_i <= 1'b0;
    wait_drained();

    for (int i = 0; i < 330; i++) begin
      calm = (i >= 150 && i < 190) || ((i / 40) % 5 == 3);
      if (i == 150) begin
        hold_req = 1'b1;
      end
      if (i == 250) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        v = brn_pkg::ValueWidth'($urandom_range(4000, 4095));
      end else if (sel < 12) begin
        v = '0;
      end else if (sel < 35) begin
        v = brn_pkg::ValueWidth'($urandom_range(1, 99));
      end else begin
        v = brn_pkg::ValueWidth'($urandom_range(1, 3999));
      end
      offer_value(v);
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    draining = 1'b1;
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/brn_pkg.sv
design/brn_front.sv
design/brn_queue.sv
design/brn_back.sv
design/binary_to_roman_numeral.sv
design/brn_checker.sv
verif/roman_checker.sv
verif/tb_top.sv
